>>> rtl/core/tmpr_pkg.sv
`timescale 1ns / 1ps

package tmpr_pkg;

  // Field widths of one input item
  localparam int MODE_W = 2;
  localparam int MIDX_W = 14;
  localparam int TIDX_W = 15;
  localparam int VAL_W  = 8;
  localparam int DIR_W  = 2;
  localparam int SX_W   = 9;
  localparam int SY_W   = 8;

  // Field widths of one result item
  localparam int COLOR_W = 8;
  localparam int VCOL_W  = 8;
  localparam int VROW_W  = 7;

  // Packed stream widths, rounded up to whole bytes
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;

  // Viewport origin registers (tile units, 8 bits each, held within the clamp limits)
  localparam int ORIGIN_W = 8;

  // Fixed-point shift of the reciprocal used to divide by the tile size
  localparam int RECIP_SH = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_WR_MAP  = 2'd0,
    MODE_WR_TILE = 2'd1,
    MODE_MOVE    = 2'd2,
    MODE_RENDER  = 2'd3
  } mode_e;

  typedef enum logic [DIR_W-1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_e;

  // Controller to datapath step commands
  typedef struct packed {
    logic clear;     // clearing pass, one entry per cycle
    logic capture;   // input transfer, latch the item
    logic exec;      // writes, move, quotient estimates
    logic rem;       // quotient correction and remainders
    logic map_rd;    // map address and read
    logic tile_rd;   // tile address and read
    logic load_out;  // load the output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic  clear_last;
    mode_e mode;
    logic  out_free;
  } dp_status_t;

endpackage

>>> rtl/core/tile_map_pixel_renderer.sv
`timescale 1ns / 1ps

// Tile map pixel renderer.
// Input stream (s_axis): one command per transfer, the mode in tuser. Modes write a
// map entry, write a tile pattern pixel, move the viewport one tile, or render one
// screen pixel. Output stream (m_axis): one result per move or render, none for
// writes; it carries the pixel color (0 for a move) and the viewport origin.
// Config channel (cfg_*): writes the layer enable bit; write it only while idle.
// Per item: a write executes; a move executes, then loads its result; a render
//   executes, corrects the remainders, reads the map then the tile pattern, and
//   loads its result. No input transfer is taken until the item is done. A render
//   is bounded by its two dependent memory reads, each with a registered read port,
//   plus the divide-by-tile-size step done as reciprocal multiply and correction.
// Reset: a clearing pass zeroes both stores, one entry per cycle in parallel, over
//   max(MAP_COLS*MAP_ROWS, TILE_COUNT*TILE_SIZE^2) entries (25600 at the defaults);
//   no input transfer is taken meanwhile, config writes are. Origin resets to 0,
//   layer enable to 1.
// Stall: the result waits in the output register; the next item is still taken and a
//   write completes, while a move or render holds until the register is free.
module tile_map_pixel_renderer #(
  parameter int MAP_COLS    = 160,
  parameter int MAP_ROWS    = 100,
  parameter int SCREEN_COLS = 32,
  parameter int SCREEN_ROWS = 18,
  parameter int TILE_SIZE   = 10,
  parameter int TILE_COUNT  = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // map_index[13:0], tile_pixel_index[28:14], write_value[36:29], direction[38:37],
  // screen_x[47:39], screen_y[55:48]
  input  logic [tmpr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // mode[1:0]
  input  logic [tmpr_pkg::MODE_W-1:0]        s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // pixel_color[7:0], view_col[15:8], view_row[22:16], zero[23]
  output logic [tmpr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic                               cfg_data_i
);
  import tmpr_pkg::*;

  dp_cmd_t              cmd;
  dp_status_t           status;
  logic [COLOR_W-1:0]   pixel_color;
  logic [VCOL_W-1:0]    view_col;
  logic [VROW_W-1:0]    view_row;

  // Controller
  tmpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath with stores and output register
  tmpr_datapath #(
    .MAP_COLS    (MAP_COLS),
    .MAP_ROWS    (MAP_ROWS),
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS),
    .TILE_SIZE   (TILE_SIZE),
    .TILE_COUNT  (TILE_COUNT)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .mode_i             (mode_e'(s_axis_tuser)),
    .map_index_i        (s_axis_tdata[13:0]),
    .tile_pixel_index_i (s_axis_tdata[28:14]),
    .write_value_i      (s_axis_tdata[36:29]),
    .direction_i        (dir_e'(s_axis_tdata[38:37])),
    .screen_x_i         (s_axis_tdata[47:39]),
    .screen_y_i         (s_axis_tdata[55:48]),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .out_ready_i        (m_axis_tready),
    .out_valid_o        (m_axis_tvalid),
    .pixel_color_o      (pixel_color),
    .view_col_o         (view_col),
    .view_row_o         (view_row)
  );

  // Result packing
  assign m_axis_tdata = {1'b0, view_row, view_col, pixel_color};

endmodule

>>> rtl/core/tmpr_ctrl.sv
`timescale 1ns / 1ps

module tmpr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tmpr_pkg::dp_status_t status_i,
  output tmpr_pkg::dp_cmd_t    cmd_o
);
  import tmpr_pkg::*;

  // ST_OUT: result pending, waiting for the output register
  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_EXEC  = 7'b0000100,
    ST_REM   = 7'b0001000,
    ST_MAP   = 7'b0010000,
    ST_TILE  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        unique case (status_i.mode)
          MODE_WR_MAP, MODE_WR_TILE: state_d = ST_IDLE;
          MODE_MOVE:                 state_d = ST_OUT;
          MODE_RENDER:               state_d = ST_REM;
          default:                   state_d = ST_IDLE;
        endcase
      end
      ST_REM: begin
        cmd_o.rem = 1'b1;
        state_d   = ST_MAP;
      end
      ST_MAP: begin
        cmd_o.map_rd = 1'b1;
        state_d      = ST_TILE;
      end
      ST_TILE: begin
        cmd_o.tile_rd = 1'b1;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // An accepted item always goes to execution next
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o && in_valid_i) |=> (state_q == ST_EXEC))
    else $error("accepted item did not enter execution");

  // A render runs on to the remainder step
  a_render_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.exec && status_i.mode == MODE_RENDER) |=> (state_q == ST_REM))
    else $error("render did not proceed to remainder step");

  // Result load only into a free output register
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (status_i.out_free && !in_ready_o))
    else $error("result loaded while output register busy");

endmodule

>>> rtl/core/tmpr_datapath.sv
`timescale 1ns / 1ps

module tmpr_datapath #(
  parameter int MAP_COLS    = 160,
  parameter int MAP_ROWS    = 100,
  parameter int SCREEN_COLS = 32,
  parameter int SCREEN_ROWS = 18,
  parameter int TILE_SIZE   = 10,
  parameter int TILE_COUNT  = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tmpr_pkg::dp_cmd_t             cmd_i,
  output tmpr_pkg::dp_status_t          status_o,
  input  tmpr_pkg::mode_e               mode_i,
  input  logic [tmpr_pkg::MIDX_W-1:0]   map_index_i,
  input  logic [tmpr_pkg::TIDX_W-1:0]   tile_pixel_index_i,
  input  logic [tmpr_pkg::VAL_W-1:0]    write_value_i,
  input  tmpr_pkg::dir_e                direction_i,
  input  logic [tmpr_pkg::SX_W-1:0]     screen_x_i,
  input  logic [tmpr_pkg::SY_W-1:0]     screen_y_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_data_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [tmpr_pkg::COLOR_W-1:0]  pixel_color_o,
  output logic [tmpr_pkg::VCOL_W-1:0]   view_col_o,
  output logic [tmpr_pkg::VROW_W-1:0]  view_row_o
);
  import tmpr_pkg::*;

  localparam int MAP_DEPTH  = MAP_COLS * MAP_ROWS;
  localparam int TILE_AREA  = TILE_SIZE * TILE_SIZE;
  localparam int TILE_DEPTH = TILE_COUNT * TILE_AREA;
  localparam int CLR_LEN    = (MAP_DEPTH > TILE_DEPTH) ? MAP_DEPTH : TILE_DEPTH;
  localparam int MAW        = $clog2(MAP_DEPTH);
  localparam int TAW        = $clog2(TILE_DEPTH);
  localparam int CW         = $clog2(CLR_LEN);
  localparam int RW         = $clog2(TILE_SIZE);
  localparam int OFW        = $clog2(TILE_AREA);
  localparam int XPW        = SX_W + RECIP_SH;
  localparam int YPW        = SY_W + RECIP_SH;
  localparam int MCW        = SX_W + 1;
  localparam int MRW        = SY_W + 1;
  localparam int RECIP      = (1 << RECIP_SH) / TILE_SIZE;
  localparam int XLIM       = SCREEN_COLS * TILE_SIZE;
  localparam int YLIM       = SCREEN_ROWS * TILE_SIZE;
  localparam int ROW_MAX    = MAP_ROWS - SCREEN_ROWS;
  localparam int COL_MAX    = MAP_COLS - SCREEN_COLS;

  // Item registers
  mode_e               mode_q;
  logic [MIDX_W-1:0]   midx_q;
  logic [TIDX_W-1:0]   tidx_q;
  logic [VAL_W-1:0]    val_q;
  dir_e                dir_q;
  logic [SX_W-1:0]     sx_q;
  logic [SY_W-1:0]     sy_q;

  // Control and state registers
  logic [CW-1:0]       clr_q;
  logic [ORIGIN_W-1:0] origin_col_q, origin_col_d;
  logic [ORIGIN_W-1:0] origin_row_q, origin_row_d;
  logic                layer_q;
  logic                out_valid_q;

  // Render pipeline registers
  logic [SX_W-1:0]     qxe_q, qx_q;
  logic [SY_W-1:0]     qye_q, qy_q;
  logic [RW-1:0]       rx_q, ry_q;
  logic                hit_q;
  logic [OFW-1:0]      pix_off_q;
  logic                draw_q;
  logic [COLOR_W-1:0]  color_q;
  logic [VCOL_W-1:0]   vcol_q;
  logic [VROW_W-1:0]   vrow_q;

  // Memories
  logic [VAL_W-1:0]    map_mem [MAP_DEPTH];
  logic [VAL_W-1:0]    tile_mem [TILE_DEPTH];
  logic [VAL_W-1:0]    map_rdata_q;
  logic [VAL_W-1:0]    tile_rdata_q;

  // Combinational
  logic [XPW-1:0]      xprod;
  logic [YPW-1:0]      yprod;
  logic [SX_W-1:0]     rxe;
  logic [SY_W-1:0]     rye;
  logic [MCW-1:0]      mc;
  logic [MRW-1:0]      mr;
  logic                on_screen;
  logic                in_map;
  logic [MAW-1:0]      map_raddr;
  logic                tile_ok;
  logic [TAW-1:0]      tile_raddr;
  logic                map_we;
  logic [MAW-1:0]      map_waddr;
  logic                tile_we;
  logic [TAW-1:0]      tile_waddr;
  logic [VAL_W-1:0]    wdata;
  logic                clear_last;

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      midx_q <= map_index_i;
      tidx_q <= tile_pixel_index_i;
      val_q  <= write_value_i;
      dir_q  <= direction_i;
      sx_q   <= screen_x_i;
      sy_q   <= screen_y_i;
    end
  end

  // Clearing pass counter
  assign clear_last = (clr_q == CW'(CLR_LEN - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear && !clear_last) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // Layer enable register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_q <= 1'b1;
    end else if (cfg_valid_i) begin
      layer_q <= cfg_data_i;
    end
  end

  // Viewport move with clamping
  always_comb begin
    origin_col_d = origin_col_q;
    origin_row_d = origin_row_q;
    if (cmd_i.exec && mode_q == MODE_MOVE) begin
      case (dir_q)
        DIR_UP: begin
          if (origin_row_q != '0) origin_row_d = origin_row_q - 1'b1;
        end
        DIR_DOWN: begin
          if (32'(origin_row_q) < ROW_MAX) origin_row_d = origin_row_q + 1'b1;
        end
        DIR_LEFT: begin
          if (origin_col_q != '0) origin_col_d = origin_col_q - 1'b1;
        end
        default: begin
          if (32'(origin_col_q) < COL_MAX) origin_col_d = origin_col_q + 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_col_q <= '0;
      origin_row_q <= '0;
    end else begin
      origin_col_q <= origin_col_d;
      origin_row_q <= origin_row_d;
    end
  end

  // Memory write ports: clearing pass or item write
  always_comb begin
    wdata      = cmd_i.clear ? '0 : val_q;
    map_waddr  = cmd_i.clear ? MAW'(clr_q) : MAW'(midx_q);
    tile_waddr = cmd_i.clear ? TAW'(clr_q) : TAW'(tidx_q);
    map_we     = (cmd_i.clear && 32'(clr_q) < MAP_DEPTH) ||
                 (cmd_i.exec && mode_q == MODE_WR_MAP && 32'(midx_q) < MAP_DEPTH);
    tile_we    = (cmd_i.clear && 32'(clr_q) < TILE_DEPTH) ||
                 (cmd_i.exec && mode_q == MODE_WR_TILE && 32'(tidx_q) < TILE_DEPTH);
  end

  // Quotient estimates: multiply by the scaled reciprocal of the tile size
  assign xprod = XPW'(sx_q) * XPW'(RECIP);
  assign yprod = YPW'(sy_q) * YPW'(RECIP);

  // Remainder before correction; estimate is exact or one low
  assign rxe = sx_q - SX_W'(32'(qxe_q) * TILE_SIZE);
  assign rye = sy_q - SY_W'(32'(qye_q) * TILE_SIZE);

  // Map cell of the pixel
  always_comb begin
    mc        = MCW'(origin_col_q) + MCW'(qx_q);
    mr        = MRW'(origin_row_q) + MRW'(qy_q);
    on_screen = (32'(sx_q) < XLIM) && (32'(sy_q) < YLIM);
    in_map    = (32'(mc) < MAP_COLS) && (32'(mr) < MAP_ROWS);
    map_raddr = MAW'(32'(mr) * MAP_COLS + 32'(mc));
  end

  // Tile pattern address
  always_comb begin
    tile_ok    = hit_q && (map_rdata_q != '0) && (32'(map_rdata_q) < TILE_COUNT);
    tile_raddr = TAW'(32'(map_rdata_q) * TILE_AREA + 32'(pix_off_q));
  end

  // Render pipeline steps
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      qxe_q <= SX_W'(xprod >> RECIP_SH);
      qye_q <= SY_W'(yprod >> RECIP_SH);
    end
    if (cmd_i.rem) begin
      if (32'(rxe) >= TILE_SIZE) begin
        qx_q <= qxe_q + 1'b1;
        rx_q <= RW'(32'(rxe) - TILE_SIZE);
      end else begin
        qx_q <= qxe_q;
        rx_q <= RW'(rxe);
      end
      if (32'(rye) >= TILE_SIZE) begin
        qy_q <= qye_q + 1'b1;
        ry_q <= RW'(32'(rye) - TILE_SIZE);
      end else begin
        qy_q <= qye_q;
        ry_q <= RW'(rye);
      end
    end
    if (cmd_i.map_rd) begin
      hit_q     <= on_screen && in_map;
      pix_off_q <= OFW'(32'(ry_q) * TILE_SIZE + 32'(rx_q));
    end
    if (cmd_i.tile_rd) begin
      draw_q <= tile_ok;
    end
  end

  // Map store
  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= wdata;
    end
    if (cmd_i.map_rd) begin
      map_rdata_q <= map_mem[map_raddr];
    end
  end

  // Tile pattern store
  always_ff @(posedge clk_i) begin
    if (tile_we) begin
      tile_mem[tile_waddr] <= wdata;
    end
    if (cmd_i.tile_rd) begin
      tile_rdata_q <= tile_mem[tile_raddr];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      color_q <= (mode_q == MODE_RENDER && draw_q && layer_q) ? tile_rdata_q : '0;
      vcol_q  <= VCOL_W'(origin_col_q);
      vrow_q  <= VROW_W'(origin_row_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_color_o = color_q;
  assign view_col_o    = vcol_q;
  assign view_row_o    = vrow_q;

  // Status to the controller
  assign status_o.clear_last = clear_last;
  assign status_o.mode       = mode_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // Viewport stays within the clamp limits
  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(origin_row_q) <= ROW_MAX)
    else $error("viewport row beyond clamp limit");

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(origin_col_q) <= COL_MAX)
    else $error("viewport column beyond clamp limit");

  // A loaded result is presented on the next cycle
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> out_valid_q)
    else $error("loaded result not presented");

endmodule

>>> tb/tile_map_pixel_renderer_test.sv
`timescale 1ns / 1ps

module tile_map_pixel_renderer_test;
  import tmpr_pkg::*;

  localparam int MAP_COLS    = 160;
  localparam int MAP_ROWS    = 100;
  localparam int SCREEN_COLS = 32;
  localparam int SCREEN_ROWS = 18;
  localparam int TILE_SIZE   = 10;
  localparam int TILE_COUNT  = 256;
  localparam int MAP_DEPTH   = MAP_COLS * MAP_ROWS;
  localparam int TILE_AREA   = TILE_SIZE * TILE_SIZE;
  localparam int TILE_DEPTH  = TILE_COUNT * TILE_AREA;

  // cycles allowed for an in-flight item after the last result
  localparam int DRAIN_CYCLES = 16;
  localparam int LIMIT_CYCLES = 600000;
  localparam int PHASE_ITEMS  = 185;

  typedef struct packed {
    logic [VROW_W-1:0]  row;
    logic [VCOL_W-1:0]  col;
    logic [COLOR_W-1:0] color;
  } view_result_t;

  // Shadow copy of the renderer: map, patterns, origin and layer enable
  class render_scoreboard;
    logic [7:0]   map_cells[MAP_DEPTH];
    logic [7:0]   tile_texels[TILE_DEPTH];
    int           org_col;
    int           org_row;
    bit           layer_on;
    int           errors;
    view_result_t expected_views[$];

    function new();
      foreach (map_cells[i]) map_cells[i] = '0;
      foreach (tile_texels[i]) tile_texels[i] = '0;
      org_col  = 0;
      org_row  = 0;
      layer_on = 1'b1;
      errors   = 0;
    endfunction

    function void set_layer(bit v);
      layer_on = v;
    endfunction

    function int pending();
      return expected_views.size();
    endfunction

    function logic [7:0] pixel_at(int sx, int sy);
      int mc, mr, tile, pidx;
      if (!layer_on) return 8'd0;
      if (sx >= SCREEN_COLS * TILE_SIZE || sy >= SCREEN_ROWS * TILE_SIZE) return 8'd0;
      mc = org_col + sx / TILE_SIZE;
      mr = org_row + sy / TILE_SIZE;
      if (mc >= MAP_COLS || mr >= MAP_ROWS) return 8'd0;
      tile = int'(map_cells[mr * MAP_COLS + mc]);
      if (tile == 0 || tile >= TILE_COUNT) return 8'd0;
      pidx = tile * TILE_AREA + (sy % TILE_SIZE) * TILE_SIZE + (sx % TILE_SIZE);
      if (pidx >= TILE_DEPTH) return 8'd0;
      return tile_texels[pidx];
    endfunction

    // Apply one accepted command; moves and renders queue a result
    function void note_input(mode_e m, logic [IN_DATA_W-1:0] d);
      int midx, tidx, sx, sy;
      view_result_t r;
      midx = int'(d[13:0]);
      tidx = int'(d[28:14]);
      sx   = int'(d[47:39]);
      sy   = int'(d[55:48]);
      r.color = '0;
      case (m)
        MODE_WR_MAP: begin
          if (midx < MAP_DEPTH) map_cells[midx] = d[36:29];
          return;
        end
        MODE_WR_TILE: begin
          if (tidx < TILE_DEPTH) tile_texels[tidx] = d[36:29];
          return;
        end
        MODE_MOVE: begin
          case (dir_e'(d[38:37]))
            DIR_UP:    if (org_row > 0) org_row--;
            DIR_DOWN:  if (org_row + SCREEN_ROWS < MAP_ROWS) org_row++;
            DIR_LEFT:  if (org_col > 0) org_col--;
            default:   if (org_col + SCREEN_COLS < MAP_COLS) org_col++;
          endcase
        end
        default: r.color = pixel_at(sx, sy);
      endcase
      r.col = org_col[VCOL_W-1:0];
      r.row = org_row[VROW_W-1:0];
      expected_views.push_back(r);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d);
      view_result_t exp_r;
      if (expected_views.size() == 0) begin
        $error("unexpected result: tdata %h", d);
        errors++;
        return;
      end
      exp_r = expected_views.pop_front();
      if (d[7:0] !== exp_r.color) begin
        $error("pixel_color: expected %0d, got %0d", exp_r.color, d[7:0]);
        errors++;
      end
      if (d[15:8] !== exp_r.col) begin
        $error("view_col: expected %0d, got %0d", exp_r.col, d[15:8]);
        errors++;
      end
      if (d[22:16] !== exp_r.row) begin
        $error("view_row: expected %0d, got %0d", exp_r.row, d[22:16]);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_valid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_data;
  logic [MODE_W-1:0]     s_user;
  logic                  m_axis_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready_o;
  logic                  cfg_data;

  render_scoreboard sb;
  bit  no_idle;
  bit  long_hold_done = 1'b0;
  int  hold_left      = 0;
  int  results_seen   = 0;
  int  cycles         = 0;

  tile_map_pixel_renderer #(
    .MAP_COLS    (MAP_COLS),
    .MAP_ROWS    (MAP_ROWS),
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS),
    .TILE_SIZE   (TILE_SIZE),
    .TILE_COUNT  (TILE_COUNT)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_tready) begin
      sb.check_result(m_axis_tdata);
      results_seen++;
    end
  end

  // Result sink: random stalls, plus one long hold-off to back up the input
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 60) begin
        long_hold_done = 1'b1;
        hold_left = 300;
        m_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 99) < 15) begin
        hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                 : $urandom_range(0, 2);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // One command transfer; a and b carry the fields that the mode uses,
  // everything else in tdata is random
  task automatic send_cmd(mode_e m, int a, int b);
    logic [IN_DATA_W-1:0] d;
    int gap;
    d[31:0]  = $urandom;
    d[55:32] = 24'($urandom);
    case (m)
      MODE_WR_MAP:  begin d[13:0] = 14'(a);  d[36:29] = 8'(b); end
      MODE_WR_TILE: begin d[28:14] = 15'(a); d[36:29] = 8'(b); end
      MODE_MOVE:    d[38:37] = 2'(a);
      default:      begin d[47:39] = 9'(a); d[55:48] = 8'(b); end
    endcase
    gap = pick_gap();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= d;
    s_user  <= m;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(m, d);
  endtask

  task automatic write_layer(bit v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_layer(v);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every result is in, then let a trailing write finish
  task automatic settle();
    s_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_directed();
    send_cmd(MODE_RENDER, 0, 0);          // empty tile after reset
    send_cmd(MODE_MOVE, DIR_UP, 0);       // clamped at top
    send_cmd(MODE_MOVE, DIR_LEFT, 0);     // clamped at left
    send_cmd(MODE_WR_MAP, 0, 1);
    send_cmd(MODE_WR_TILE, 100, 8'hAB);
    send_cmd(MODE_RENDER, 0, 0);
    send_cmd(MODE_WR_TILE, 199, 8'hFF);
    send_cmd(MODE_RENDER, 9, 9);
    send_cmd(MODE_RENDER, 1, 0);          // pattern color 0
    // out-of-range writes are dropped
    send_cmd(MODE_WR_MAP, MAP_DEPTH, 2);
    send_cmd(MODE_WR_MAP, 16383, 3);
    send_cmd(MODE_WR_TILE, TILE_DEPTH, 7);
    send_cmd(MODE_WR_TILE, 32767, 7);
    send_cmd(MODE_WR_MAP, MAP_DEPTH - 1, 255);
    send_cmd(MODE_WR_TILE, TILE_DEPTH - 1, 8'h55);
    send_cmd(MODE_RENDER, SCREEN_COLS * TILE_SIZE - 1, SCREEN_ROWS * TILE_SIZE - 1);
    // off-screen pixels
    send_cmd(MODE_RENDER, SCREEN_COLS * TILE_SIZE, 0);
    send_cmd(MODE_RENDER, 0, SCREEN_ROWS * TILE_SIZE);
    send_cmd(MODE_RENDER, 511, 255);
    send_cmd(MODE_MOVE, DIR_DOWN, 0);
    send_cmd(MODE_MOVE, DIR_RIGHT, 0);
    send_cmd(MODE_WR_MAP, MAP_COLS + 1, 1);
    send_cmd(MODE_RENDER, 9, 9);
    send_cmd(MODE_RENDER, 0, 0);
  endtask

  task automatic run_random(int count);
    int n, r, idx, val, dir, len;
    n = 0;
    while (n < count) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        // render, mostly on screen
        if ($urandom_range(0, 9) == 0)
          send_cmd(MODE_RENDER, $urandom_range(0, 511), $urandom_range(0, 255));
        else
          send_cmd(MODE_RENDER, $urandom_range(0, SCREEN_COLS * TILE_SIZE - 1),
                   $urandom_range(0, SCREEN_ROWS * TILE_SIZE - 1));
        n++;
      end else if (r < 58) begin
        // map write, mostly inside the current view with a few tile numbers
        if ($urandom_range(0, 9) == 0)
          idx = $urandom_range(0, 16383);
        else
          idx = (sb.org_row + $urandom_range(0, SCREEN_ROWS - 1)) * MAP_COLS
                + sb.org_col + $urandom_range(0, SCREEN_COLS - 1);
        val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
        send_cmd(MODE_WR_MAP, idx, val);
        n++;
      end else if (r < 78) begin
        // pattern write, mostly to the tiles the map uses
        if ($urandom_range(0, 9) == 0)
          idx = $urandom_range(0, 32767);
        else
          idx = $urandom_range(1, 3) * TILE_AREA + $urandom_range(0, TILE_AREA - 1);
        val = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 255);
        send_cmd(MODE_WR_TILE, idx, val);
        n++;
      end else if (r < 90) begin
        send_cmd(MODE_MOVE, $urandom_range(0, 3), 0);
        n++;
      end else if (r < 98) begin
        // noise: any mode, any field values
        send_cmd(mode_e'($urandom_range(0, 3)), $urandom, $urandom);
        n++;
      end else if ($urandom_range(0, 2) == 0) begin
        // run of moves toward an edge and a few past it
        dir = $urandom_range(0, 3);
        case (dir_e'(dir))
          DIR_UP:   len = sb.org_row;
          DIR_DOWN: len = MAP_ROWS - SCREEN_ROWS - sb.org_row;
          DIR_LEFT: len = sb.org_col;
          default:  len = MAP_COLS - SCREEN_COLS - sb.org_col;
        endcase
        len += $urandom_range(1, 4);
        repeat (len) send_cmd(MODE_MOVE, dir, 0);
        n += len;
      end else begin
        send_cmd(MODE_MOVE, $urandom_range(0, 3), 0);
        n++;
      end
    end
  endtask

  // Main sequence
  initial begin
    sb = new();
    no_idle   = 1'b0;
    rst_ni    <= 1'b0;
    s_valid   <= 1'b0;
    s_data    <= '0;
    s_user    <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_layer(1'b1);
    run_directed();
    settle();

    for (int p = 0; p < 5; p++) begin
      write_layer((p == 1 || p == 3) ? 1'b0 : 1'b1);
      no_idle = (p == 2);
      run_random(PHASE_ITEMS);
      settle();
    end
    no_idle = 1'b0;

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
